// ===== rtl/rbst_pkg.sv =====
// Shared constants and sideband types for the ray/box slab test.
package rbst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DEF_COORD_WIDTH = 32;
  localparam int NUM_AXES = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;

  // per-axis flags that travel beside the divider lanes
  typedef struct packed {
    logic neg0;  // quotient for the lower bound is negative
    logic neg1;  // quotient for the upper bound is negative
    logic zdir;  // direction component is zero
  } axis_side_t;

  typedef struct packed {
    axis_side_t [NUM_AXES-1:0] ax;
    logic                      miss;  // zero-direction axis with origin outside its slab
  } side_t;

endpackage

// ===== rtl/ray_box_slab_test.sv =====
// Top level of the ray against axis-aligned box slab test.
//
// Usage: present a ray (origin, direction) and a box (min, max bounds) on the
// in_ channel, all signed Q16.16. One transfer happens when in_valid is high
// and in_stall is low. Each input transfer produces exactly one output
// transfer on the out_ channel: out_hit, and out_entry_distance (Q16.16,
// saturated to the port range, zero on a miss).
// Stages, in order: one prep stage, one divider stage per quotient bit in six
// parallel restoring divider lanes (two bounds per axis), two reduction stages,
// one output stage.
// Throughput: one ray/box pair per cycle while the receiver does not stall, set by the fully pipelined dividers.
// Reset (rst_n low, synchronous) drops every item in flight; out_valid falls.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated, and bubbles
// are not squeezed out while the stall lasts.
module ray_box_slab_test #(
  parameter int COORD_WIDTH = rbst_pkg::DEF_COORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_WIDTH-1:0] out_entry_distance
);
  import rbst_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = CW + FRAC_BITS;          // numerator and quotient width
  localparam int SW  = (NW > 62) ? 64 : NW + 1;  // signed distance width
  localparam int LAT = NW + 3;                   // prep + divider + reduce stages

  logic out_valid_r;

  // global advance: the pipeline moves whenever the output register can take data
  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // gather the axes
  logic signed [CW-1:0] org  [NUM_AXES];
  logic signed [CW-1:0] dir  [NUM_AXES];
  logic signed [CW-1:0] bmin [NUM_AXES];
  logic signed [CW-1:0] bmax [NUM_AXES];

  assign org  = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir  = '{in_dir_x, in_dir_y, in_dir_z};
  assign bmin = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign bmax = '{in_box_max_x, in_box_max_y, in_box_max_z};

  // prep stage: magnitudes of bound offsets and direction, signs, zero-direction test
  logic [NW-1:0] num_nxt [NUM_LANES];
  logic [CW-1:0] den_nxt [NUM_AXES];
  side_t         side_nxt;
  logic [NUM_AXES-1:0] zmiss;

  genvar a;
  generate
    for (a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [CW:0] d0;
      logic signed [CW:0] d1;
      logic [CW:0]        nd0;
      logic [CW:0]        nd1;
      logic [CW-1:0]      mag0;
      logic [CW-1:0]      mag1;
      logic               dneg;
      logic signed [CW-1:0] lo;
      logic signed [CW-1:0] hi;

      assign d0   = {bmin[a][CW-1], bmin[a]} - {org[a][CW-1], org[a]};
      assign d1   = {bmax[a][CW-1], bmax[a]} - {org[a][CW-1], org[a]};
      assign nd0  = -d0;
      assign nd1  = -d1;
      assign mag0 = d0[CW] ? nd0[CW-1:0] : d0[CW-1:0];
      assign mag1 = d1[CW] ? nd1[CW-1:0] : d1[CW-1:0];
      assign dneg = dir[a][CW-1];

      assign num_nxt[2*a]   = {mag0, {FRAC_BITS{1'b0}}};
      assign num_nxt[2*a+1] = {mag1, {FRAC_BITS{1'b0}}};
      assign den_nxt[a]     = dneg ? CW'(-dir[a]) : dir[a];

      assign side_nxt.ax[a].neg0 = d0[CW] ^ dneg;
      assign side_nxt.ax[a].neg1 = d1[CW] ^ dneg;
      assign side_nxt.ax[a].zdir = dir[a] == '0;

      // zero direction: the origin must lie inside the slab, bounds in either order
      assign lo       = (bmin[a] < bmax[a]) ? bmin[a] : bmax[a];
      assign hi       = (bmin[a] < bmax[a]) ? bmax[a] : bmin[a];
      assign zmiss[a] = side_nxt.ax[a].zdir && (org[a] < lo || org[a] > hi);
    end
  endgenerate

  assign side_nxt.miss = |zmiss;

  logic [NW-1:0] num_r  [NUM_LANES];
  logic [CW-1:0] den_r  [NUM_AXES];
  side_t         side_r [NW+1];
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r     <= num_nxt;
      den_r     <= den_nxt;
      side_r[0] <= side_nxt;
      for (int s = 1; s <= NW; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // six divider lanes: lower and upper bound per axis
  logic [NW-1:0] quo [NUM_LANES];

  genvar l;
  generate
    for (l = 0; l < NUM_LANES; l++) begin : g_div
      rbst_div #(
        .NW (NW),
        .DW (CW)
      ) u_div (
        .clk (clk),
        .en  (adv),
        .num (num_r[l]),
        .den (den_r[l/2]),
        .quo (quo[l])
      );
    end
  endgenerate

  logic signed [SW-1:0] entry;
  logic signed [SW-1:0] exit_d;
  logic                 miss;

  rbst_reduce #(
    .NW (NW),
    .SW (SW)
  ) u_reduce (
    .clk    (clk),
    .en     (adv),
    .quo    (quo),
    .side   (side_r[NW]),
    .entry  (entry),
    .exit_d (exit_d),
    .miss   (miss)
  );

  // output stage: hit decision and saturation to the port range
  localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic                 hit_nxt;
  logic signed [CW-1:0] dist_nxt;
  logic                 hit_r;
  logic signed [CW-1:0] dist_r;

  always_comb begin
    hit_nxt = !(miss || exit_d < 0 || entry > exit_d);
    if (!hit_nxt) begin
      dist_nxt = '0;
    end else if (entry > MAXV) begin
      dist_nxt = MAXV[CW-1:0];
    end else if (entry < MINV) begin
      dist_nxt = MINV[CW-1:0];
    end else begin
      dist_nxt = entry[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_entry_distance = dist_r;

  // a miss always reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_entry_distance == '0)
    else $error("miss with nonzero entry distance");

  // a held pipeline keeps every valid bit in place
  a_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid chain moved during stall");

  // a result leaving the last reduce stage lands in the output register
  a_land: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[LAT-1] |=> out_valid)
    else $error("result lost at output stage");

endmodule

// ===== rtl/rbst_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per register stage.
module rbst_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  // numerator bits shift out at the top while quotient bits shift in at the bottom
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];

  genvar s;
  generate
    for (s = 0; s < NW; s++) begin : g_stage
      logic [NW-1:0] nq_in;
      logic [DW-1:0] rem_in;
      logic [DW-1:0] den_in;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
        assign nq_in  = num;
        assign rem_in = '0;
        assign den_in = den;
      end else begin : g_next
        assign nq_in  = nq_r[s-1];
        assign rem_in = rem_r[s-1];
        assign den_in = den_r[s-1];
      end

      assign trial = {rem_in, nq_in[NW-1]};
      assign ge    = trial >= {1'b0, den_in};
      assign diff  = trial - {1'b0, den_in};

      always_ff @(posedge clk) begin
        if (en) begin
          nq_r[s]  <= {nq_in[NW-2:0], ge};
          rem_r[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          den_r[s] <= den_in;
        end
      end
    end
  endgenerate

  assign quo = nq_r[NW-1];

endmodule

// ===== rtl/rbst_reduce.sv =====
// Slab reduction: signed distances, per-axis entry/exit, then overall entry/exit.
module rbst_reduce #(
  parameter int NW = 48,
  parameter int SW = 49
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NW-1:0]        quo [rbst_pkg::NUM_LANES],
  input  rbst_pkg::side_t      side,
  output logic signed [SW-1:0] entry,
  output logic signed [SW-1:0] exit_d,
  output logic                 miss
);
  import rbst_pkg::*;

  localparam int MW = SW - 1;
  localparam logic [63:0] WIDE_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic signed [SW-1:0] SENT =
    (SW == 64) ? SW'(WIDE_LIMIT) : {1'b0, {(SW-1){1'b1}}};

  logic signed [SW-1:0] t    [NUM_LANES];
  logic signed [SW-1:0] lo_r [NUM_AXES];
  logic signed [SW-1:0] hi_r [NUM_AXES];
  logic                 miss_a_r;
  logic signed [SW-1:0] entry_r;
  logic signed [SW-1:0] exit_r;
  logic                 miss_r;

  genvar l;
  generate
    for (l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [MW-1:0] mag;
      logic          neg;
      if (NW > 62) begin : g_sat
        localparam logic [NW-1:0] LIM = NW'(WIDE_LIMIT);
        assign mag = (quo[l] > LIM) ? MW'(WIDE_LIMIT) : quo[l][MW-1:0];
      end else begin : g_nosat
        assign mag = quo[l];
      end
      assign neg  = (l % 2 == 0) ? side.ax[l/2].neg0 : side.ax[l/2].neg1;
      assign t[l] = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  endgenerate

  // stage A: order each axis's pair; a zero-direction axis sets no bound
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (side.ax[a].zdir) begin
          lo_r[a] <= -SENT;
          hi_r[a] <= SENT;
        end else if (t[2*a] < t[2*a+1]) begin
          lo_r[a] <= t[2*a];
          hi_r[a] <= t[2*a+1];
        end else begin
          lo_r[a] <= t[2*a+1];
          hi_r[a] <= t[2*a];
        end
      end
      miss_a_r <= side.miss;
    end
  end

  // stage B: largest entry, smallest exit
  logic signed [SW-1:0] entry_nxt;
  logic signed [SW-1:0] exit_nxt;

  always_comb begin
    entry_nxt = lo_r[0];
    exit_nxt  = hi_r[0];
    for (int a = 1; a < NUM_AXES; a++) begin
      if (lo_r[a] > entry_nxt) entry_nxt = lo_r[a];
      if (hi_r[a] < exit_nxt)  exit_nxt  = hi_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;
      miss_r  <= miss_a_r;
    end
  end

  assign entry  = entry_r;
  assign exit_d = exit_r;
  assign miss   = miss_r;

endmodule

// ===== tb/sv/tb_ray_box_slab_test.sv =====
// Self-checking testbench for the ray/box slab intersection block.
module tb_ray_box_slab_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = rbst_pkg::DEF_COORD_WIDTH;
  localparam int LAT = W + rbst_pkg::FRAC_BITS + 4;
  localparam longint WIDE_LIM = 64'sd1 <<< 62;
  localparam longint Q_ONE = 64'sd65536;

  typedef logic signed [W-1:0] coord_t;

  // one ray/box pair: index 0..2 axes
  typedef struct {
    coord_t org [3];
    coord_t dir [3];
    coord_t bmin [3];
    coord_t bmax [3];
  } ray_box_t;

  typedef struct {
    logic   hit;
    coord_t entry_dist;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  coord_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  coord_t in_box_min_x = '0, in_box_min_y = '0, in_box_min_z = '0;
  coord_t in_box_max_x = '0, in_box_max_y = '0, in_box_max_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_hit;
  coord_t out_entry_distance;

  ray_box_slab_test #(.COORD_WIDTH(W)) u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hit_rec_t expected_hits[$];
  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // Exact truncated quotient (bound - org) * 2^16 / dir, clamped to 2^62.
  // Magnitudes stay under 2^33 * 2^16, so 64-bit math is exact at W = 32.
  function automatic longint slab_dist(longint bound, longint org, longint dir);
    longint num, q;
    num = (bound - org) * Q_ONE;
    q = num / dir;
    if (q > WIDE_LIM) q = WIDE_LIM;
    if (q < -WIDE_LIM) q = -WIDE_LIM;
    return q;
  endfunction

  function automatic hit_rec_t predict_hit(ray_box_t rb);
    hit_rec_t r;
    longint entry, leave, t0, t1, lo, hi, o, d, b0, b1;
    logic miss;
    entry = -WIDE_LIM;
    leave = WIDE_LIM;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      o = rb.org[a]; d = rb.dir[a]; b0 = rb.bmin[a]; b1 = rb.bmax[a];
      if (d == 0) begin
        lo = (b0 < b1) ? b0 : b1;
        hi = (b0 < b1) ? b1 : b0;
        if (o < lo || o > hi) miss = 1'b1;
      end else begin
        t0 = slab_dist(b0, o, d);
        t1 = slab_dist(b1, o, d);
        lo = (t0 < t1) ? t0 : t1;
        hi = (t0 < t1) ? t1 : t0;
        if (lo > entry) entry = lo;
        if (hi < leave) leave = hi;
      end
    end
    if (miss || leave < 0 || entry > leave) begin
      r.hit = 1'b0;
      r.entry_dist = '0;
    end else begin
      // saturate to the port range
      if (entry > 64'sd2147483647) entry = 64'sd2147483647;
      if (entry < -64'sd2147483648) entry = -64'sd2147483648;
      r.hit = 1'b1;
      r.entry_dist = entry[W-1:0];
    end
    return r;
  endfunction

  // Offer one pair, wait for the transfer, then record the expectation.
  // Valid stays high after the transfer so pairs can follow back to back.
  task automatic send_ray_box(ray_box_t rb);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= rb.org[0]; in_origin_y <= rb.org[1]; in_origin_z <= rb.org[2];
    in_dir_x <= rb.dir[0]; in_dir_y <= rb.dir[1]; in_dir_z <= rb.dir[2];
    in_box_min_x <= rb.bmin[0]; in_box_min_y <= rb.bmin[1]; in_box_min_z <= rb.bmin[2];
    in_box_max_x <= rb.bmax[0]; in_box_max_y <= rb.bmax[1]; in_box_max_z <= rb.bmax[2];
    do @(posedge clk); while (in_stall);
    expected_hits.push_back(predict_hit(rb));
  endtask

  // Receiver: random stalls, plus a long counted hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n ? ($urandom_range(99) < recv_stall_pct) : 1'b1;
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    hit_rec_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b dist=%0d", $time, out_hit,
                 out_entry_distance);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (out_hit !== e.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, out_hit);
          errors++;
        end
        if (out_entry_distance !== e.entry_dist) begin
          $display("%0t: entry_distance expected %0d actual %0d", $time, e.entry_dist,
                   out_entry_distance);
          errors++;
        end
      end
    end
  end

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_hits.size() != 0);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(32'h7fff)) - 32'sd16384);
      2: return coord_t'({$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)});
      3: return coord_t'(32'sd0);
      default: return coord_t'($signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000);
    endcase
  endfunction

  // Mostly sensible geometry: box around random center, ray aimed near it.
  function automatic ray_box_t rand_ray_box();
    ray_box_t rb;
    longint c, h;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(9) == 0) begin
        rb.org[a] = rand_coord(); rb.dir[a] = rand_coord();
        rb.bmin[a] = rand_coord(); rb.bmax[a] = rand_coord();
      end else begin
        c = $signed($urandom_range(32'h00ff_ffff)) - 32'sh0080_0000;
        h = $urandom_range(32'h0004_0000);
        rb.bmin[a] = coord_t'(c - h);
        rb.bmax[a] = coord_t'(c + h);
        rb.org[a] = rand_coord();
        rb.dir[a] = ($urandom_range(11) == 0) ? coord_t'(0) :
                    coord_t'((c - rb.org[a]) + $signed($urandom_range(32'hffff)) - 32'sd32768);
        if (rb.dir[a] == 0 && $urandom_range(1)) rb.dir[a] = rand_coord();
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t make_ray_box(coord_t o, coord_t d, coord_t lo, coord_t hi);
    ray_box_t rb;
    for (int a = 0; a < 3; a++) begin
      rb.org[a] = o; rb.dir[a] = d; rb.bmin[a] = lo; rb.bmax[a] = hi;
    end
    return rb;
  endfunction

  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam coord_t ONE = 32'sh0001_0000;

  task automatic test_directed();
    ray_box_t rb;
    // plain hit along +x from outside
    rb = make_ray_box(0, 0, -ONE, ONE);
    rb.org[0] = -5 * ONE; rb.dir[0] = ONE;
    send_ray_box(rb);
    // origin inside the box: negative entry
    rb = make_ray_box(0, ONE, -ONE, ONE);
    send_ray_box(rb);
    // box behind the ray: negative exit
    rb = make_ray_box(5 * ONE, ONE, -ONE, ONE);
    send_ray_box(rb);
    // all directions zero, origin inside: most negative entry
    send_ray_box(make_ray_box(0, 0, -ONE, ONE));
    // zero direction, origin outside the slab
    send_ray_box(make_ray_box(3 * ONE, 0, -ONE, ONE));
    // zero direction, origin on the boundary
    send_ray_box(make_ray_box(ONE, 0, -ONE, ONE));
    // swapped bounds, with and without zero direction
    send_ray_box(make_ray_box(-4 * ONE, ONE, ONE, -ONE));
    send_ray_box(make_ray_box(0, 0, ONE, -ONE));
    // extreme coordinates and huge distances; the first pair has a saturated entry
    rb = make_ray_box(CMIN, 1, CMAX, CMAX);
    send_ray_box(rb);
    send_ray_box(make_ray_box(CMAX, CMIN, CMIN, CMIN));
    send_ray_box(make_ray_box(CMIN, CMAX, CMAX, CMAX));
    send_ray_box(make_ray_box(CMAX, -1, CMIN, CMAX));
    send_ray_box(make_ray_box(CMIN, CMIN, CMIN, CMAX));
    send_ray_box(make_ray_box(CMAX, CMAX, CMAX, CMAX));
    send_ray_box(make_ray_box(-1, -1, -1, -1));
    // miss: slabs do not overlap
    rb = make_ray_box(0, ONE, 2 * ONE, 3 * ONE);
    rb.dir[1] = -ONE;
    send_ray_box(rb);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_ray_box(rand_ray_box());
  endtask

  // Hold the receiver off long enough for the pipeline to fill and stall.
  task automatic test_backpressure();
    drain_results();
    hold_cycles = 4 * LAT;
    test_random(3 * LAT);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_gap_pct = 7; recv_stall_pct = 73;
    test_random(600);
    test_backpressure();
    send_gap_pct = 73; recv_stall_pct = 7;
    test_random(600);
    send_gap_pct = 0; recv_stall_pct = 0;
    test_random(550);
    drain_results();
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
